[design/remote_button_mode_controller_macros.svh]
// Assertion macros shared by the remote button mode controller.
`ifndef REMOTE_BUTTON_MODE_CONTROLLER_MACROS_SVH
`define REMOTE_BUTTON_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet during rst.
`define RBMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbmc: same-cycle check failed");

// Next-cycle implication, clocked on clk and quiet during rst.
`define RBMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbmc: next-cycle check failed");

`endif

[design/rbmc_pkg.sv]
// Types, codes and packet text tables of the remote button mode controller.
package rbmc_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_POWER_ON_HOLD  = 2'd0;
  localparam logic [1:0] REG_POWER_OFF_HOLD = 2'd1;
  localparam logic [1:0] REG_SHORT_PRESS    = 2'd2;
  localparam logic [1:0] REG_IDLE_TIMEOUT   = 2'd3;

  localparam logic [31:0] POWER_ON_HOLD_RST  = 32'd5000;
  localparam logic [31:0] POWER_OFF_HOLD_RST = 32'd2000;
  localparam logic [31:0] SHORT_PRESS_RST    = 32'd600;
  localparam logic [31:0] IDLE_TIMEOUT_RST   = 32'd60000;

  // Modes
  localparam logic [1:0] SEL_INTENSITY = 2'd0;
  localparam logic [1:0] SEL_COLOR     = 2'd1;
  localparam logic [1:0] SEL_DEPTH     = 2'd2;

  localparam logic [2:0] INT_MAX   = 3'd5;
  localparam logic [2:0] INT_RST   = 3'd1;
  localparam logic [1:0] COL_MAX   = 2'd2;
  localparam logic [1:0] COL_RST   = 2'd1;

  // Packet segments of one poll
  localparam logic [1:0] SEG_START = 2'd0;
  localparam logic [1:0] SEG_UP    = 2'd1;
  localparam logic [1:0] SEG_DOWN  = 2'd2;
  localparam logic [1:0] SEG_NONE  = 2'd3;

  localparam logic [2:0] START_LAST = 3'd5;
  localparam logic [2:0] STATE_LAST = 3'd2;
  localparam logic [1:0] OUTER_LAST = 2'd2;

  // Index snapshot carried with one full-state send
  typedef struct packed {
    logic       send;
    logic [2:0] int_idx;
    logic [1:0] col_idx;
    logic       dep_idx;
  } snap_t;

  // One classified poll
  typedef struct packed {
    logic       startup;
    snap_t      up;
    snap_t      down;
    logic       powered;
    logic [1:0] mode;
  } job_t;

  function automatic logic [47:0] int_text(input logic [2:0] idx);
    logic [47:0] t;
    unique case (idx)
      3'd0:    t = "@I01#T";
      3'd1:    t = "@I02#T";
      3'd2:    t = "@I04#T";
      3'd3:    t = "@I06#T";
      3'd4:    t = "@I08#T";
      default: t = "@I0:#T";
    endcase
    return t;
  endfunction

  function automatic logic [47:0] col_text(input logic [1:0] idx);
    logic [47:0] t;
    unique case (idx)
      2'd0:    t = "@C-5#T";
      2'd1:    t = "@C05#T";
      default: t = "@C+5#T";
    endcase
    return t;
  endfunction

  function automatic logic [47:0] dep_text(input logic idx);
    logic [47:0] t;
    unique case (idx)
      1'b0:    t = "@D_0#T";
      default: t = "@D_1#T";
    endcase
    return t;
  endfunction

  function automatic logic [47:0] start_text(input logic [2:0] idx);
    logic [47:0] t;
    unique case (idx)
      3'd0:    t = "@I01#T";
      3'd1:    t = "@D_0#T";
      3'd2:    t = "@L_1#T";
      3'd3:    t = "@F_0#T";
      3'd4:    t = "@E_0#T";
      default: t = "@C05#T";
    endcase
    return t;
  endfunction

  function automatic logic [7:0] chan_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = "L";
      2'd1:    c = "R";
      default: c = "M";
    endcase
    return c;
  endfunction

endpackage

[design/rbmc_queue.sv]
// Short job queue between the poll classifier and the packet emitter.
module rbmc_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rbmc_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output rbmc_pkg::job_t  head,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rbmc_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= bump(wptr);
      end
      if (pop && !empty) begin
        rptr <= bump(rptr);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CW'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[design/rbmc_front.sv]
// Poll classifier: button timing, power, mode and index state, job build.
module rbmc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [31:0]     time_ms,
  input  logic            button_power,
  input  logic            button_up,
  input  logic            button_down,
  output logic            job_push,
  output rbmc_pkg::job_t  job,
  input  logic            q_full
);

  logic [31:0] power_on_hold_ms;
  logic [31:0] power_off_hold_ms;
  logic [31:0] short_press_max_ms;
  logic [31:0] idle_timeout_ms;

  logic        power_state,     power_state_next;
  logic [1:0]  mode_state,      mode_state_next;
  logic [2:0]  intensity_index, intensity_index_next;
  logic [1:0]  color_index,     color_index_next;
  logic        depth_index,     depth_index_next;
  logic        power_button_previous;
  logic [31:0] press_start_ms,  press_start_ms_next;
  logic [31:0] last_activity,   last_activity_next;

  logic        accept;
  logic        fall;
  logic [31:0] dur;
  logic [31:0] idle_gap;
  logic        pwr1;
  logic [1:0]  mode1;
  logic        turn_on;
  logic [2:0]  ii_u, ii_d;
  logic [1:0]  ci_u, ci_d;
  logic        di_u, di_d;
  logic        up_send, dn_send, sent;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign job_push = accept;

  always_comb begin
    fall     = !button_power && power_button_previous;
    dur      = time_ms - press_start_ms;
    idle_gap = time_ms - last_activity;

    press_start_ms_next = (button_power && !power_button_previous) ? time_ms
                                                                   : press_start_ms;

    // button one
    pwr1    = power_state;
    mode1   = mode_state;
    turn_on = 1'b0;
    if (fall) begin
      priority if (!power_state && dur >= power_on_hold_ms) begin
        pwr1    = 1'b1;
        turn_on = 1'b1;
      end else if (power_state && dur >= power_off_hold_ms) begin
        pwr1 = 1'b0;
      end else if (power_state && dur < short_press_max_ms) begin
        mode1 = (mode_state >= rbmc_pkg::SEL_DEPTH) ? rbmc_pkg::SEL_INTENSITY
                                                     : mode_state + 2'd1;
      end
    end

    // button two: step up
    up_send = pwr1 && button_up;
    ii_u = intensity_index;
    ci_u = color_index;
    di_u = depth_index;
    if (up_send) begin
      if (mode1 == rbmc_pkg::SEL_INTENSITY && intensity_index < rbmc_pkg::INT_MAX) begin
        ii_u = intensity_index + 3'd1;
      end
      if (mode1 == rbmc_pkg::SEL_COLOR && color_index < rbmc_pkg::COL_MAX) begin
        ci_u = color_index + 2'd1;
      end
      if (mode1 == rbmc_pkg::SEL_DEPTH) begin
        di_u = 1'b1;
      end
    end

    // button three: step down
    dn_send = pwr1 && button_down;
    ii_d = ii_u;
    ci_d = ci_u;
    di_d = di_u;
    if (dn_send) begin
      if (mode1 == rbmc_pkg::SEL_INTENSITY && ii_u != 3'd0) begin
        ii_d = ii_u - 3'd1;
      end
      if (mode1 == rbmc_pkg::SEL_COLOR && ci_u != 2'd0) begin
        ci_d = ci_u - 2'd1;
      end
      if (mode1 == rbmc_pkg::SEL_DEPTH) begin
        di_d = 1'b0;
      end
    end

    // any send refreshes activity to now, so the idle gap is then zero
    sent               = turn_on || up_send || dn_send;
    last_activity_next = sent ? time_ms : last_activity;
    power_state_next   = pwr1 && (sent || !(idle_gap > idle_timeout_ms));

    mode_state_next      = mode1;
    intensity_index_next = ii_d;
    color_index_next     = ci_d;
    depth_index_next     = di_d;

    job.startup      = turn_on;
    job.up.send      = up_send;
    job.up.int_idx   = ii_u;
    job.up.col_idx   = ci_u;
    job.up.dep_idx   = di_u;
    job.down.send    = dn_send;
    job.down.int_idx = ii_d;
    job.down.col_idx = ci_d;
    job.down.dep_idx = di_d;
    job.powered      = power_state_next;
    job.mode         = mode_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on_hold_ms   <= rbmc_pkg::POWER_ON_HOLD_RST;
      power_off_hold_ms  <= rbmc_pkg::POWER_OFF_HOLD_RST;
      short_press_max_ms <= rbmc_pkg::SHORT_PRESS_RST;
      idle_timeout_ms    <= rbmc_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rbmc_pkg::REG_POWER_ON_HOLD:  power_on_hold_ms   <= cfg_data;
        rbmc_pkg::REG_POWER_OFF_HOLD: power_off_hold_ms  <= cfg_data;
        rbmc_pkg::REG_SHORT_PRESS:    short_press_max_ms <= cfg_data;
        default:                      idle_timeout_ms    <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_state           <= 1'b0;
      mode_state            <= rbmc_pkg::SEL_INTENSITY;
      intensity_index       <= rbmc_pkg::INT_RST;
      color_index           <= rbmc_pkg::COL_RST;
      depth_index           <= 1'b0;
      power_button_previous <= 1'b0;
      press_start_ms        <= '0;
      last_activity         <= '0;
    end else if (accept) begin
      power_state           <= power_state_next;
      mode_state            <= mode_state_next;
      intensity_index       <= intensity_index_next;
      color_index           <= color_index_next;
      depth_index           <= depth_index_next;
      power_button_previous <= button_power;
      press_start_ms        <= press_start_ms_next;
      last_activity         <= last_activity_next;
    end
  end

endmodule

[design/rbmc_back.sv]
// Packet emitter: walks one job's packet segments into the output register.
module rbmc_back (
  input  logic            clk,
  input  logic            rst,
  input  rbmc_pkg::job_t  head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [55:0]     packet_text,
  output logic            packet_valid,
  output logic            powered,
  output logic [1:0]      current_mode,
  output logic            led_red,
  output logic            led_green,
  output logic            led_blue,
  output logic            final_res
);

  logic        busy;
  logic [1:0]  seg;
  logic [1:0]  outer;
  logic [2:0]  inner;

  logic        can_load, fire;
  logic [1:0]  cur_seg;
  logic [1:0]  cur_outer;
  logic [2:0]  cur_inner;
  logic        last_inner, seg_done, has_next, job_done;
  logic [1:0]  nseg;
  rbmc_pkg::snap_t snap;
  logic [47:0] body;
  logic [55:0] text;

  assign can_load = !out_valid || !out_stall;
  assign fire     = !q_empty && can_load;

  always_comb begin
    priority if (busy)         cur_seg = seg;
    else if (head.startup)     cur_seg = rbmc_pkg::SEG_START;
    else if (head.up.send)     cur_seg = rbmc_pkg::SEG_UP;
    else if (head.down.send)   cur_seg = rbmc_pkg::SEG_DOWN;
    else                       cur_seg = rbmc_pkg::SEG_NONE;
    cur_outer = busy ? outer : 2'd0;
    cur_inner = busy ? inner : 3'd0;

    last_inner = (cur_seg == rbmc_pkg::SEG_START) ? (cur_inner == rbmc_pkg::START_LAST)
                                                  : (cur_inner == rbmc_pkg::STATE_LAST);
    seg_done = (cur_seg == rbmc_pkg::SEG_NONE) ||
               (last_inner && cur_outer == rbmc_pkg::OUTER_LAST);

    has_next = 1'b0;
    nseg     = rbmc_pkg::SEG_NONE;
    unique case (cur_seg)
      rbmc_pkg::SEG_START: begin
        if (head.up.send) begin
          has_next = 1'b1;
          nseg     = rbmc_pkg::SEG_UP;
        end else if (head.down.send) begin
          has_next = 1'b1;
          nseg     = rbmc_pkg::SEG_DOWN;
        end
      end
      rbmc_pkg::SEG_UP: begin
        if (head.down.send) begin
          has_next = 1'b1;
          nseg     = rbmc_pkg::SEG_DOWN;
        end
      end
      default: begin
        has_next = 1'b0;
      end
    endcase
    job_done = seg_done && !has_next;

    // Start packets run channel outer, string inner; state packets run
    // group outer, channel inner.
    snap = (cur_seg == rbmc_pkg::SEG_DOWN) ? head.down : head.up;
    unique case (cur_outer)
      2'd0:    body = rbmc_pkg::int_text(snap.int_idx);
      2'd1:    body = rbmc_pkg::col_text(snap.col_idx);
      default: body = rbmc_pkg::dep_text(snap.dep_idx);
    endcase
    unique case (cur_seg)
      rbmc_pkg::SEG_START: text = {rbmc_pkg::start_text(cur_inner),
                                   rbmc_pkg::chan_char(cur_outer)};
      rbmc_pkg::SEG_NONE:  text = '0;
      default:             text = {body, rbmc_pkg::chan_char(cur_inner[1:0])};
    endcase
  end

  assign q_pop = fire && job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      seg   <= rbmc_pkg::SEG_NONE;
      outer <= '0;
      inner <= '0;
    end else if (fire) begin
      if (job_done) begin
        busy <= 1'b0;
      end else begin
        busy <= 1'b1;
        if (seg_done) begin
          seg   <= nseg;
          outer <= '0;
          inner <= '0;
        end else if (last_inner) begin
          seg   <= cur_seg;
          outer <= cur_outer + 2'd1;
          inner <= '0;
        end else begin
          seg   <= cur_seg;
          outer <= cur_outer;
          inner <= cur_inner + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      packet_text  <= text;
      packet_valid <= (cur_seg != rbmc_pkg::SEG_NONE);
      powered      <= head.powered;
      current_mode <= head.mode;
      final_res    <= job_done;
    end
  end

  assign led_red   = powered && (current_mode == rbmc_pkg::SEL_INTENSITY);
  assign led_green = powered && (current_mode == rbmc_pkg::SEL_COLOR);
  assign led_blue  = powered && (current_mode == rbmc_pkg::SEL_DEPTH);

endmodule

[design/remote_button_mode_controller.sv]
// Top level of the remote button mode controller.
//
// Each input transaction is one button poll (time plus three button levels).
// The front end takes a poll whenever the job queue has room, updates power,
// mode and index state at once and queues a job that describes the packets
// the poll causes. The packet emitter drains the queue and delivers one result
// transaction per cycle while out_stall is low: 18 startup packets on power
// on, nine full-state packets for each step of button two or three (up to 36
// in all), or one empty result (packet_valid low) when the poll sends nothing.
// A poll thus yields 1 to 36 results; the emitter's single output port sets
// the sustained rate, while the front end runs ahead by up to QUEUE_DEPTH
// polls. Status fields on every result of a poll show the state after the
// whole poll. Configuration writes are registered and are meant for idle
// periods only. No clearing pass is needed after reset.
`include "remote_button_mode_controller_macros.svh"

module remote_button_mode_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // poll channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] time_ms,
  input  logic        button_power,
  input  logic        button_up,
  input  logic        button_down,
  // packet channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [55:0] packet_text,
  output logic        packet_valid,
  output logic        powered,
  output logic [1:0]  current_mode,
  output logic        led_red,
  output logic        led_green,
  output logic        led_blue,
  output logic        final_res
);

  rbmc_pkg::job_t push_job;
  rbmc_pkg::job_t head_job;
  logic           job_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // classify polls and hold all controller state
  rbmc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .time_ms      (time_ms),
    .button_power (button_power),
    .button_up    (button_up),
    .button_down  (button_down),
    .job_push     (job_push),
    .job          (push_job),
    .q_full       (q_full)
  );

  // decouple the classifier from packet delivery
  rbmc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty)
  );

  // expand each job into packets, one per cycle unless stalled, behind an output register
  rbmc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_job),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packet_text  (packet_text),
    .packet_valid (packet_valid),
    .powered      (powered),
    .current_mode (current_mode),
    .led_red      (led_red),
    .led_green    (led_green),
    .led_blue     (led_blue),
    .final_res    (final_res)
  );

  // an empty result is always the only, and so the last, result of its poll
  `RBMC_ASSERT_IMP(a_empty_is_final, out_valid && !packet_valid, final_res)
  // a packet is only ever sent while the unit ends the poll powered
  `RBMC_ASSERT_IMP(a_packet_powered, out_valid && packet_valid, powered)
  // packets of one poll follow without a gap once a non-final one is taken
  `RBMC_ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !final_res, out_valid)

endmodule
